>>> design/crp_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the reply frame parser.
`default_nettype none

package crp_pkg;

  // Frame geometry.
  localparam int FRAME_LEN   = 11;
  localparam int CRC_SPAN    = 7;
  localparam int STORE_DEPTH = FRAME_LEN - 1;
  localparam int COUNT_W     = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
  localparam logic [COUNT_W-1:0] LAST_POS   = 4'(FRAME_LEN - 1);
  localparam logic [COUNT_W-1:0] CRC_END    = 4'(CRC_SPAN);
  localparam logic [COUNT_W-1:0] STORE_END  = 4'(STORE_DEPTH);

  // CRC-16/XMODEM.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // Fixed frames, byte 0 in the top byte.
  localparam logic [8*FRAME_LEN-1:0] CRC_ERR_FRAME = 88'hff_00_00_33_02_60_fa_5b_39_55_aa;
  localparam logic [8*FRAME_LEN-1:0] DATA_OK_FRAME = 88'hff_00_00_22_02_a0_01_68_1c_55_aa;

  // Framing bytes of a command reply.
  localparam logic [7:0] HDR_SYNC  = 8'hff;
  localparam logic [7:0] HDR_ZERO  = 8'h00;
  localparam logic [7:0] HDR_ADDR  = 8'h00;
  localparam logic [7:0] HDR_TYPE  = 8'h11;
  localparam logic [7:0] HDR_LEN   = 8'h02;
  localparam logic [7:0] TRL_FIRST = 8'h55;
  localparam logic [7:0] TRL_LAST  = 8'haa;
  localparam logic [7:0] RSP_OK    = 8'h01;
  localparam logic [7:0] RSP_ERR   = 8'hfa;

  typedef enum logic [2:0] {
    ST_UNPACK_ER = 3'd0,
    ST_CRC_ER    = 3'd1,
    ST_DATA_OK   = 3'd2,
    ST_CMD_OK    = 3'd3,
    ST_CMD_ER    = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } byte_word_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] command_code;
  } reply_word_t;

  // Handshake between the input register and the frame core.
  typedef struct packed {
    logic hold_valid;
  } hold_ctl_t;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/crp_in_stage.sv
// Input register that holds one received byte word until the frame core takes it.
`default_nettype none

module crp_in_stage
  import crp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire byte_word_t byte_word,
  input  wire logic       fire,
  output hold_ctl_t       ctl,
  output byte_word_t      hold_word
);

  logic hold_valid;

  // The register is free when empty or when its word moves on this cycle.
  assign byte_stall = hold_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      hold_word <= byte_word;
    end
  end

  assign ctl.hold_valid = hold_valid;

endmodule

`default_nettype wire

>>> design/crp_frame_core.sv
// Byte count, running CRC, frame byte store and classification of a finished frame.
`default_nettype none

module crp_frame_core
  import crp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire hold_ctl_t   ctl,
  input  wire byte_word_t  hold_word,
  input  wire logic        reply_free,
  output logic             fire,
  output logic             res_fire,
  output reply_word_t      result
);

  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [15:0]        crc_accumulator;
  logic [15:0]        crc_accumulator_next;
  logic [7:0]         frame_bytes [STORE_DEPTH];
  logic [8*FRAME_LEN-1:0] frame_vec;
  logic               framing_ok;
  logic               crc_ok;

  // A non-final byte always moves; a final byte needs room in the result register.
  assign fire     = ctl.hold_valid && (!hold_word.frame_end || reply_free);
  assign res_fire = fire && hold_word.frame_end;

  // Count and CRC update for the byte in the input register.
  always_comb begin
    crc_accumulator_next = crc_accumulator;
    if (byte_count < CRC_END) begin
      crc_accumulator_next = crc_byte(crc_accumulator, hold_word.data_byte);
    end
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 4'd1 : COUNT_MAX;
    if (hold_word.frame_end) begin
      byte_count_next      = '0;
      crc_accumulator_next = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      crc_accumulator <= CRC_INIT;
    end else if (fire) begin
      byte_count      <= byte_count_next;
      crc_accumulator <= crc_accumulator_next;
    end
  end

  // Store bytes 0 to 9; byte 10 is the current byte when the frame is classified.
  always_ff @(posedge clk) begin
    if (fire && byte_count < STORE_END) begin
      frame_bytes[byte_count] <= hold_word.data_byte;
    end
  end

  // Whole frame with byte 0 on top.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      frame_vec[8*(FRAME_LEN-1-i) +: 8] = frame_bytes[i];
    end
    frame_vec[7:0] = hold_word.data_byte;
  end

  assign crc_ok = frame_bytes[7] == crc_accumulator[7:0] &&
                  frame_bytes[8] == crc_accumulator[15:8];

  assign framing_ok = frame_bytes[0] == HDR_SYNC && frame_bytes[1] == HDR_ZERO &&
                      frame_bytes[2] == HDR_ADDR && frame_bytes[3] == HDR_TYPE &&
                      frame_bytes[4] == HDR_LEN  && frame_bytes[9] == TRL_FIRST &&
                      hold_word.data_byte == TRL_LAST;

  // Classification, in order of precedence. Only an 11-byte frame can pass.
  always_comb begin
    result.status       = ST_UNPACK_ER;
    result.command_code = 8'h00;
    if (byte_count == LAST_POS) begin
      if (frame_vec == CRC_ERR_FRAME) begin
        result.status = ST_CRC_ER;
      end else if (frame_vec == DATA_OK_FRAME) begin
        result.status = ST_DATA_OK;
      end else if (crc_ok && framing_ok) begin
        if (frame_bytes[6] == RSP_OK) begin
          result.status       = ST_CMD_OK;
          result.command_code = frame_bytes[5];
        end else if (frame_bytes[6] == RSP_ERR) begin
          result.status       = ST_CMD_ER;
          result.command_code = frame_bytes[5];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/crp_out_stage.sv
// Result register that holds one reply word until the receiver takes it.
`default_nettype none

module crp_out_stage
  import crp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_fire,
  input  wire reply_word_t result,
  output logic             reply_free,
  output logic             reply_valid,
  input  wire logic        reply_stall,
  output reply_word_t      reply_word
);

  // Free when empty or when the waiting word is taken this cycle.
  assign reply_free = !reply_valid || !reply_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (reply_free) begin
      reply_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_free && res_fire) begin
      reply_word <= result;
    end
  end

endmodule

`default_nettype wire

>>> design/crc_checked_reply_frame_parser.sv
// Top level of the CRC-16/XMODEM checked reply frame parser.
//
//   Channel  Dir  Handshake                 Word
//   byte     in   byte_valid / byte_stall   byte_word  (data_byte, frame_end)
//   reply    out  reply_valid / reply_stall reply_word (status, command_code)
//
// One byte word is taken per cycle while the input register is not stalled. A byte waits in the input register
// and the frame core updates the count, CRC and store from there; a final byte
// moves its reply into the result register once that register is free, and the reply
// is offered from there. Only a final byte waits on a stalled result register.
// Reset clears the count, the CRC and both valid flags; no clearing pass is needed.
`default_nettype none

module crc_checked_reply_frame_parser
  import crp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire byte_word_t  byte_word,
  output logic             reply_valid,
  input  wire logic        reply_stall,
  output reply_word_t      reply_word
);

  hold_ctl_t   ctl;
  byte_word_t  hold_word;
  logic        fire;
  logic        res_fire;
  logic        reply_free;
  reply_word_t result;

  crp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .fire       (fire),
    .ctl        (ctl),
    .hold_word  (hold_word)
  );

  crp_frame_core u_frame_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .hold_word  (hold_word),
    .reply_free (reply_free),
    .fire       (fire),
    .res_fire   (res_fire),
    .result     (result)
  );

  crp_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .res_fire    (res_fire),
    .result      (result),
    .reply_free  (reply_free),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply_word  (reply_word)
  );

endmodule

`default_nettype wire

>>> design/crp_checker.sv
// Port-level checks of the reply frame parser and their binding to the top level.
`default_nettype none

module crp_checker
  import crp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        byte_valid,
  input wire logic        byte_stall,
  input wire byte_word_t  byte_word,
  input wire logic        reply_valid,
  input wire logic        reply_stall,
  input wire reply_word_t reply_word
);

  // A stalled reply word stays in place.
  a_reply_hold: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_stall |=> reply_valid && $stable(reply_word))
    else $error("reply word changed while stalled");

  // Input backs up only behind a stalled reply.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> reply_valid && reply_stall)
    else $error("byte channel stalled without a stalled reply");

  // Only command replies carry a command code.
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_word.status != ST_CMD_OK && reply_word.status != ST_CMD_ER
      |-> reply_word.command_code == 8'h00)
    else $error("command code set on a non-command reply");

  // No reply is left over from before reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> !reply_valid && !byte_stall)
    else $error("reply valid or stall right after reset");

endmodule

bind crc_checked_reply_frame_parser crp_checker u_crp_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .byte_word   (byte_word),
  .reply_valid (reply_valid),
  .reply_stall (reply_stall),
  .reply_word  (reply_word)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the CRC-16/XMODEM checked reply frame parser.
`default_nettype none

module tb;
  import crp_pkg::*;

  typedef logic [7:0] frame_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  byte_word_t  byte_word = '0;
  logic        reply_valid;
  logic        reply_stall = 1'b0;
  reply_word_t reply_word;

  // Byte words waiting to be offered, and replies the parser still owes.
  byte_word_t  pending_bytes[$];
  reply_word_t expected_replies[$];

  // Shadow copy of the parser state.
  logic [3:0]  rx_count = '0;
  logic [15:0] rx_crc = CRC_INIT;
  logic [7:0]  rx_bytes [0:FRAME_LEN-1];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_replies = 1'b0;
  int error_count = 0;
  int queued_bytes = 0;

  crc_checked_reply_frame_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply_word  (reply_word)
  );

  always #1 clk = ~clk;

  // CRC-16/XMODEM update, one input bit at a time starting at the MSB.
  function automatic logic [15:0] crc16_xmodem_next(input logic [15:0] crc,
                                                    input logic [7:0] d);
    logic [15:0] r;
    logic fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Track one accepted byte and queue the reply that a final byte produces.
  task automatic predict_reply(input byte_word_t w);
    reply_word_t r;
    logic [3:0] len;
    logic [8*FRAME_LEN-1:0] whole;
    if (rx_count < FRAME_LEN) begin
      rx_bytes[rx_count] = w.data_byte;
    end
    if (rx_count < CRC_SPAN) begin
      rx_crc = crc16_xmodem_next(rx_crc, w.data_byte);
    end
    len = (rx_count < COUNT_MAX) ? rx_count + 4'd1 : COUNT_MAX;
    if (!w.frame_end) begin
      rx_count = len;
    end else begin
      r.status = ST_UNPACK_ER;
      r.command_code = 8'h00;
      if (len == FRAME_LEN) begin
        whole = '0;
        for (int i = 0; i < FRAME_LEN; i++) begin
          whole = {whole[8*FRAME_LEN-9:0], rx_bytes[i]};
        end
        if (whole == CRC_ERR_FRAME) begin
          r.status = ST_CRC_ER;
        end else if (whole == DATA_OK_FRAME) begin
          r.status = ST_DATA_OK;
        end else if (rx_bytes[7] == rx_crc[7:0] && rx_bytes[8] == rx_crc[15:8] &&
                     whole[87:48] == {HDR_SYNC, HDR_ZERO, HDR_ADDR, HDR_TYPE, HDR_LEN} &&
                     rx_bytes[9] == TRL_FIRST && rx_bytes[10] == TRL_LAST) begin
          if (rx_bytes[6] == RSP_OK) begin
            r.status = ST_CMD_OK;
            r.command_code = rx_bytes[5];
          end else if (rx_bytes[6] == RSP_ERR) begin
            r.status = ST_CMD_ER;
            r.command_code = rx_bytes[5];
          end
        end
      end
      expected_replies = {expected_replies, r};
      rx_count = '0;
      rx_crc = CRC_INIT;
    end
  endtask

  // Well-formed command reply with a correct CRC.
  function automatic frame_q_t cmd_reply(input logic [7:0] code, input logic [7:0] rsp);
    frame_q_t f;
    logic [15:0] crc;
    f = '{HDR_SYNC, HDR_ZERO, HDR_ADDR, HDR_TYPE, HDR_LEN, code, rsp};
    crc = CRC_INIT;
    foreach (f[i]) begin
      crc = crc16_xmodem_next(crc, f[i]);
    end
    f = {f, crc[7:0], crc[15:8], TRL_FIRST, TRL_LAST};
    return f;
  endfunction

  function automatic frame_q_t fixed_frame(input logic [8*FRAME_LEN-1:0] bits);
    frame_q_t f;
    for (int i = 0; i < FRAME_LEN; i++) begin
      f = {f, bits[8*(FRAME_LEN-1-i) +: 8]};
    end
    return f;
  endfunction

  // Turn a frame into byte words, the last one flagged as the frame end.
  task automatic queue_frame(input frame_q_t f);
    byte_word_t w;
    foreach (f[i]) begin
      w.data_byte = f[i];
      w.frame_end = (i == f.size() - 1);
      pending_bytes = {pending_bytes, w};
    end
    queued_bytes += f.size();
  endtask

  // Mostly valid command replies, plus corrupted, odd-length and noise frames.
  task automatic add_random_frame();
    frame_q_t f;
    int kind;
    int pick;
    int n;
    logic [7:0] rsp;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    rsp = (pick < 4) ? RSP_OK : (pick < 8) ? RSP_ERR : 8'($urandom);
    if (kind < 55) begin
      f = cmd_reply(8'($urandom), rsp);
    end else if (kind < 70) begin
      f = cmd_reply(8'($urandom), rsp);
      n = $urandom_range(0, FRAME_LEN - 1);
      f[n] = f[n] ^ (8'd1 << $urandom_range(0, 7));
    end else if (kind < 78) begin
      f = fixed_frame(($urandom_range(0, 1) == 1) ? CRC_ERR_FRAME : DATA_OK_FRAME);
      if ($urandom_range(0, 1) == 1) begin
        n = $urandom_range(0, FRAME_LEN - 1);
        f[n] = f[n] ^ (8'd1 << $urandom_range(0, 7));
      end
    end else if (kind < 90) begin
      n = $urandom_range(1, 20);
      repeat (n) f = {f, 8'($urandom)};
    end else begin
      // Valid reply cut short or padded out past the saturation point.
      f = cmd_reply(8'($urandom), rsp);
      n = $urandom_range(1, 18);
      while (f.size() > n) void'(f.pop_back());
      while (f.size() < n) f = {f, 8'($urandom)};
    end
    queue_frame(f);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_valid || expected_replies.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Sender: offers the next byte word once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        predict_reply(byte_word);
      end
      if (!byte_valid || !byte_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          byte_word <= pending_bytes.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken reply word against the oldest expectation.
  always @(posedge clk) begin
    reply_word_t exp_w;
    if (rst) begin
      reply_stall <= 1'b0;
    end else begin
      if (reply_valid && !reply_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: status %0d, command_code %02h",
                 reply_word.status, reply_word.command_code);
          error_count++;
        end else begin
          exp_w = expected_replies.pop_front();
          if (reply_word.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, reply_word.status);
            error_count++;
          end
          if (reply_word.command_code !== exp_w.command_code) begin
            $error("command_code: expected %02h, got %02h",
                   exp_w.command_code, reply_word.command_code);
            error_count++;
          end
        end
      end
      reply_stall <= hold_replies || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    frame_q_t f;
    int send_pct [4];
    int recv_pct [4];
    int target;
    send_pct = '{0, 69, 0, 13};
    recv_pct = '{0, 0, 69, 13};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Fixed replies, both command outcomes at code extremes, a short frame,
    // a bad CRC, an unknown response byte and a frame past the count limit.
    queue_frame(fixed_frame(CRC_ERR_FRAME));
    queue_frame(fixed_frame(DATA_OK_FRAME));
    queue_frame(cmd_reply(8'h00, RSP_OK));
    queue_frame(cmd_reply(8'hff, RSP_ERR));
    queue_frame('{8'h00});
    f = cmd_reply(8'h3c, RSP_OK);
    f[7] = f[7] ^ 8'h01;
    queue_frame(f);
    queue_frame(cmd_reply(8'h5a, 8'h7e));
    f = cmd_reply(8'h81, RSP_OK);
    repeat (6) f = {f, 8'($urandom)};
    queue_frame(f);
    wait_drained();

    // Random frames under each idling mix.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      target = queued_bytes + 190;
      while (queued_bytes < target) add_random_frame();
      wait_drained();
    end

    // Hold replies off for a long stretch while bytes keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_replies = 1'b1;
    repeat (6) queue_frame(cmd_reply(8'($urandom), RSP_OK));
    repeat (150) @(negedge clk);
    hold_replies = 1'b0;
    wait_drained();

    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
